FILE: rtl/iidl_pkg.sv
// ----------------------------------------------------------------------------
// iidl_pkg
// Shared types and constants for the indexed insert/delete list: command and
// status codes, request/response payloads and the per-cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package iidl_pkg;

  // list depth and derived widths
  localparam int unsigned CAPACITY = 256;
  localparam int unsigned PosW     = $clog2(CAPACITY);
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned RdCntW   = PosW + 1;
  localparam int unsigned DataW    = 32;
  localparam int unsigned IdxW     = 16;
  localparam int unsigned LenW     = 9;

  // command codes
  typedef enum logic [2:0] {
    CMD_READ       = 3'd0,
    CMD_INS_HEAD   = 3'd1,
    CMD_APPEND     = 3'd2,
    CMD_INS_BEFORE = 3'd3,
    CMD_DELETE     = 3'd4
  } cmd_e;

  // status codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } ctrl_state_e;

  // request payload
  typedef struct packed {
    logic [2:0]              cmd;
    logic signed [IdxW-1:0]  index;
    logic signed [DataW-1:0] value_in;
  } in_req_t;

  // response payload
  typedef struct packed {
    logic signed [DataW-1:0] value_out;
    logic                    found;
    logic [LenW-1:0]         length;
    logic [1:0]              status;
  } out_rsp_t;

  // control broadcast to every cell
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [PosW-1:0]   pos;
    logic [PosW-1:0]   rd_pos;
    logic [DataW-1:0]  value;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/iidl_cell.sv
// ----------------------------------------------------------------------------
// iidl_cell
// One list slot. Shifts right on insert, left on delete, and forwards the
// read tap toward the head one cell per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module iidl_cell (
  input  wire                              clk_i,
  input  wire iidl_pkg::cell_ctl_t         ctl_i,
  input  wire [iidl_pkg::PosW-1:0]         cell_pos_i,
  input  wire [iidl_pkg::DataW-1:0]        left_i,
  input  wire [iidl_pkg::DataW-1:0]        right_i,
  input  wire [iidl_pkg::DataW-1:0]        tap_right_i,
  output logic [iidl_pkg::DataW-1:0]       entry_o,
  output logic [iidl_pkg::DataW-1:0]       tap_o
);

  logic [iidl_pkg::DataW-1:0] entry_q, entry_d;
  logic [iidl_pkg::DataW-1:0] tap_q, tap_d;

  // entry update: open or close the gap
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins) begin
      if (cell_pos_i > ctl_i.pos) begin
        entry_d = left_i;
      end else if (cell_pos_i == ctl_i.pos) begin
        entry_d = ctl_i.value;
      end
    end else if (ctl_i.del) begin
      if (cell_pos_i >= ctl_i.pos) begin
        entry_d = right_i;
      end
    end
  end

  // read tap: pick up own entry at the read position, else pass along
  always_comb begin
    if (cell_pos_i == ctl_i.rd_pos) begin
      tap_d = entry_q;
    end else begin
      tap_d = tap_right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    tap_q   <= tap_d;
  end

  assign entry_o = entry_q;
  assign tap_o   = tap_q;

endmodule

`default_nettype wire

FILE: rtl/iidl_ctrl.sv
// ----------------------------------------------------------------------------
// iidl_ctrl
// Command decode, entry count, read sequencing and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module iidl_ctrl (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire iidl_pkg::in_req_t       in_req_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output iidl_pkg::out_rsp_t           out_rsp_o,
  input  wire [iidl_pkg::DataW-1:0]    tap_i,
  output iidl_pkg::cell_ctl_t          ctl_o
);

  iidl_pkg::ctrl_state_e state_q, state_d;

  logic [iidl_pkg::CntW-1:0]   count_q, count_d;
  logic [iidl_pkg::RdCntW-1:0] rd_cnt_q, rd_cnt_d;
  logic [iidl_pkg::PosW-1:0]   rd_pos_q, rd_pos_d;
  logic                        out_valid_q, out_valid_d;
  iidl_pkg::out_rsp_t          out_rsp_q, out_rsp_d;

  logic                        accept;
  logic                        out_free;
  logic                        read_done;
  logic                        idx_neg;
  logic [iidl_pkg::IdxW-1:0]   idx_u;
  logic [iidl_pkg::IdxW-1:0]   cnt_ext;
  logic                        in_range;
  logic                        idx_past;
  logic                        full;
  logic                        want_ins;
  logic                        do_ins;
  logic                        do_del;
  logic                        start_read;
  logic [iidl_pkg::PosW-1:0]   op_pos;
  iidl_pkg::status_e           status;

  // index checks against the current length
  assign idx_neg  = in_req_i.index[iidl_pkg::IdxW-1];
  assign idx_u    = in_req_i.index;
  assign cnt_ext  = iidl_pkg::IdxW'(count_q);
  assign in_range = !idx_neg && (idx_u < cnt_ext);
  assign idx_past = !idx_neg && (idx_u > cnt_ext);
  assign full     = count_q >= iidl_pkg::CntW'(iidl_pkg::CAPACITY);
  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && in_ready_o;

  // command decode
  always_comb begin
    want_ins   = 1'b0;
    do_del     = 1'b0;
    start_read = 1'b0;
    op_pos     = '0;
    status     = iidl_pkg::ST_DONE;
    unique case (in_req_i.cmd)
      iidl_pkg::CMD_READ: begin
        if (in_range) begin
          start_read = 1'b1;
          op_pos     = idx_u[iidl_pkg::PosW-1:0];
        end else begin
          status = iidl_pkg::ST_IGNORED;
        end
      end
      iidl_pkg::CMD_INS_HEAD: begin
        want_ins = 1'b1;
      end
      iidl_pkg::CMD_APPEND: begin
        want_ins = 1'b1;
        op_pos   = iidl_pkg::PosW'(count_q);
      end
      iidl_pkg::CMD_INS_BEFORE: begin
        if (idx_neg) begin
          want_ins = 1'b1;
        end else if (idx_past) begin
          status = iidl_pkg::ST_IGNORED;
        end else begin
          want_ins = 1'b1;
          op_pos   = idx_u[iidl_pkg::PosW-1:0];
        end
      end
      iidl_pkg::CMD_DELETE: begin
        if (in_range) begin
          do_del = 1'b1;
          op_pos = idx_u[iidl_pkg::PosW-1:0];
        end else begin
          status = iidl_pkg::ST_IGNORED;
        end
      end
      default: begin
        status = iidl_pkg::ST_IGNORED;
      end
    endcase
    do_ins = want_ins && !full;
    if (want_ins && full) begin
      status = iidl_pkg::ST_FULL;
    end
  end

  // cell control broadcast
  assign ctl_o.ins    = accept && do_ins;
  assign ctl_o.del    = accept && do_del;
  assign ctl_o.pos    = op_pos;
  assign ctl_o.rd_pos = rd_pos_q;
  assign ctl_o.value  = in_req_i.value_in;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      iidl_pkg::S_IDLE: begin
        if (accept && start_read) begin
          state_d = iidl_pkg::S_READ;
        end
      end
      iidl_pkg::S_READ: begin
        if (rd_cnt_q == '0 && out_free) begin
          state_d = iidl_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = iidl_pkg::S_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    read_done  = 1'b0;
    unique case (state_q)
      iidl_pkg::S_IDLE: begin
        in_ready_o = out_free;
      end
      iidl_pkg::S_READ: begin
        read_done = (rd_cnt_q == '0) && out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // count, read counter and read position
  always_comb begin
    count_d  = count_q;
    rd_cnt_d = rd_cnt_q;
    rd_pos_d = rd_pos_q;
    if (ctl_o.ins) begin
      count_d = count_q + 1'b1;
    end else if (ctl_o.del) begin
      count_d = count_q - 1'b1;
    end
    if (accept && start_read) begin
      rd_pos_d = op_pos;
      rd_cnt_d = {1'b0, op_pos} + 1'b1;
    end else if (state_q == iidl_pkg::S_READ && rd_cnt_q != '0) begin
      rd_cnt_d = rd_cnt_q - 1'b1;
    end
  end

  // response register
  always_comb begin
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept && !start_read) begin
      out_valid_d         = 1'b1;
      out_rsp_d.value_out = '1;
      out_rsp_d.found     = 1'b0;
      out_rsp_d.length    = iidl_pkg::LenW'(count_d);
      out_rsp_d.status    = status;
    end else if (read_done) begin
      out_valid_d         = 1'b1;
      out_rsp_d.value_out = tap_i;
      out_rsp_d.found     = 1'b1;
      out_rsp_d.length    = iidl_pkg::LenW'(count_q);
      out_rsp_d.status    = iidl_pkg::ST_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iidl_pkg::S_IDLE;
      count_q     <= '0;
      rd_cnt_q    <= '0;
      rd_pos_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_cnt_q    <= rd_cnt_d;
      rd_pos_q    <= rd_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // length stays within capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= iidl_pkg::CntW'(iidl_pkg::CAPACITY))
    else $error("entry count above capacity");

  // never shift both ways at once
  a_one_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_o.ins && ctl_o.del))
    else $error("insert and delete together");

  // no insert into a full list
  a_ins_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.ins |-> !full)
    else $error("insert while full");

  // the list does not change while a read walks the tap chain
  a_read_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iidl_pkg::S_READ) |=> $stable(count_q) && $stable(rd_pos_q))
    else $error("list changed during read");

  // a read in range always enters the read walk
  a_read_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && start_read) |=> (state_q == iidl_pkg::S_READ))
    else $error("read not started");

endmodule

`default_nettype wire

FILE: rtl/indexed_insert_delete_list.sv
// ----------------------------------------------------------------------------
// indexed_insert_delete_list
// Bounded ordered list of signed 32-bit values with indexed read, insert and
// delete, built as a row of cells.
// ----------------------------------------------------------------------------
// The list is a row of CAPACITY cells, each holding one entry. Insert and
// delete shift every cell at or past the position by one place at once, so
// those commands, and any command that is ignored or dropped, present their
// response in the cycle after the request is accepted. A read in range
// travels through the tap chain toward the head one cell per cycle, and
// its response is registered once the output is free. One request is
// worked at a time; a new request is taken while a response waits only once
// that response is being taken. value_out is -1 except for a read that hits.
`default_nettype none

module indexed_insert_delete_list (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire iidl_pkg::in_req_t in_req_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output iidl_pkg::out_rsp_t    out_rsp_o
);

  iidl_pkg::cell_ctl_t        ctl;
  logic [iidl_pkg::DataW-1:0] entry [iidl_pkg::CAPACITY];
  logic [iidl_pkg::DataW-1:0] tap   [iidl_pkg::CAPACITY];

  // controller
  iidl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .tap_i       (tap[0]),
    .ctl_o       (ctl)
  );

  // row of cells, head at position zero
  for (genvar k = 0; k < iidl_pkg::CAPACITY; k++) begin : g_cell
    logic [iidl_pkg::DataW-1:0] left;
    logic [iidl_pkg::DataW-1:0] right;
    logic [iidl_pkg::DataW-1:0] tap_right;

    if (k == 0) begin : g_head
      assign left = '0;
    end else begin : g_body
      assign left = entry[k-1];
    end

    if (k == iidl_pkg::CAPACITY - 1) begin : g_tail
      assign right     = '0;
      assign tap_right = '0;
    end else begin : g_mid
      assign right     = entry[k+1];
      assign tap_right = tap[k+1];
    end

    iidl_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .cell_pos_i  (iidl_pkg::PosW'(k)),
      .left_i      (left),
      .right_i     (right),
      .tap_right_i (tap_right),
      .entry_o     (entry[k]),
      .tap_o       (tap[k])
    );
  end

endmodule

`default_nettype wire
